@@ src/tva_pkg.sv @@
// ----------------------------------------------------------------------------
// tva_pkg
// Shared types, constants and arithmetic helpers for the vertex AABB block.
// ----------------------------------------------------------------------------
package tva_pkg;

    localparam int COORD_BITS = 16;

    localparam int FIELD_W  = 16;
    localparam int VERT_W   = FIELD_W + 1;
    localparam int VSHIFT   = (COORD_BITS < FIELD_W) ? (FIELD_W - COORD_BITS) : 0;
    localparam int PROD_W   = FIELD_W + VERT_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int FRAC_SH  = 12;
    localparam int SHR_W    = SUM_W - FRAC_SH;
    localparam int OUT_W    = 21;
    localparam int AXES     = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 128;

    localparam logic [1:0] ROW_UNUSED = 2'd3;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic {
        OP_VERTEX = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef logic signed [FIELD_W-1:0] word_t;
    typedef logic signed [OUT_W-1:0]   coord_t;

    typedef struct packed {
        op_t                 op;
        logic [1:0]          row_index;
        word_t [AXES-1:0]    coef;
        word_t               offset;
        logic [AXES-1:0][FIELD_W-1:0] vert;
        logic                last;
    } in_item_t;

    typedef struct packed {
        logic              last;
        coord_t [AXES-1:0] t;
    } fifo_entry_t;

    typedef struct packed {
        logic        valid;
        fifo_entry_t entry;
    } fifo_push_t;

    typedef struct packed {
        logic             empty;
        logic [CNT_W-1:0] count;
    } fifo_status_t;

    function automatic logic signed [VERT_W-1:0] vert_ext(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] sh;
        sh = v << VSHIFT;
        if (COORD_BITS > FIELD_W) begin
            return {1'b0, v};
        end
        return $signed({sh[FIELD_W-1], sh}) >>> VSHIFT;
    endfunction

    function automatic coord_t clamp_out(input logic signed [SHR_W-1:0] v);
        if (v[SHR_W-1:OUT_W-1] == '0 || v[SHR_W-1:OUT_W-1] == '1) begin
            return v[OUT_W-1:0];
        end
        return v[SHR_W-1] ? OUT_MIN : OUT_MAX;
    endfunction

endpackage

@@ src/transformed_vertex_aabb.sv @@
// ----------------------------------------------------------------------------
// transformed_vertex_aabb
// Bounding box of a mesh after a 3x4 fixed-point affine transform.
// ----------------------------------------------------------------------------
// Transfers are taken one per cycle while s_tready is high, matrix row loads
// and vertices alike. A vertex is multiplied in the cycle it is taken, summed
// and pushed into a four-entry queue on the next edge, and folded into the box
// when it leaves the queue; the box of a mesh shows on m_tvalid once its last
// vertex leaves the queue. s_tready drops only when the queue and the multiply
// stage hold four vertices, i.e. when the box output has stalled long enough.
module transformed_vertex_aabb import tva_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // row_index[1:0] coef_x[17:2] coef_y[33:18] coef_z[49:34] offset[65:50]
    // vert_x[81:66] vert_y[97:82] vert_z[113:98], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // min_x[20:0] min_y[41:21] min_z[62:42] max_x[83:63] max_y[104:84]
    // max_z[125:105], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    in_item_t          in_item;
    fifo_status_t      fifo_status;
    fifo_push_t        push;
    fifo_entry_t       head;
    logic              pop;
    coord_t [AXES-1:0] out_min;
    coord_t [AXES-1:0] out_max;

    always_comb begin
        in_item.op        = op_t'(s_tuser);
        in_item.row_index = s_tdata[1:0];
        in_item.coef[0]   = s_tdata[17:2];
        in_item.coef[1]   = s_tdata[33:18];
        in_item.coef[2]   = s_tdata[49:34];
        in_item.offset    = s_tdata[65:50];
        in_item.vert[0]   = s_tdata[81:66];
        in_item.vert[1]   = s_tdata[97:82];
        in_item.vert[2]   = s_tdata[113:98];
        in_item.last      = s_tlast;
    end

    assign m_tdata = {2'b00, out_max[2], out_max[1], out_max[0],
                      out_min[2], out_min[1], out_min[0]};

    tva_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_item     (in_item),
        .fifo_status (fifo_status),
        .push        (push)
    );

    tva_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .status  (fifo_status)
    );

    tva_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .fifo_status (fifo_status),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_min     (out_min),
        .out_max     (out_max)
    );

endmodule

@@ src/tva_front.sv @@
// ----------------------------------------------------------------------------
// tva_front
// Accepts items, holds the matrix, multiplies vertices and pushes transformed
// coordinates into the queue.
// ----------------------------------------------------------------------------
module tva_front import tva_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  in_item_t     in_item,
    input  fifo_status_t fifo_status,
    output fifo_push_t   push
);

    word_t coef_reg [AXES][AXES];
    word_t moff_reg [AXES];

    logic signed [PROD_W-1:0] prod_reg [AXES][AXES];
    logic signed [PROD_W-1:0] prod     [AXES][AXES];
    word_t                    poff_reg [AXES];
    logic                     plast_reg;
    logic                     p_valid_reg;

    logic signed [VERT_W-1:0] vert [AXES];
    logic signed [SUM_W-1:0]  sum  [AXES];
    logic                     accept;

    assign in_ready = (fifo_status.count + CNT_W'(p_valid_reg)) < CNT_W'(FIFO_DEPTH);
    assign accept   = in_valid && in_ready;

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            vert[k] = vert_ext(in_item.vert[k]);
        end
        for (int a = 0; a < AXES; a++) begin
            for (int k = 0; k < AXES; k++) begin
                prod[a][k] = coef_reg[a][k] * vert[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                moff_reg[a] <= '0;
                for (int k = 0; k < AXES; k++) begin
                    coef_reg[a][k] <= '0;
                end
            end
        end else if (accept && in_item.op == OP_LOAD && in_item.row_index != ROW_UNUSED) begin
            for (int a = 0; a < AXES; a++) begin
                if (in_item.row_index == 2'(a)) begin
                    moff_reg[a] <= in_item.offset;
                    for (int k = 0; k < AXES; k++) begin
                        coef_reg[a][k] <= in_item.coef[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= accept && in_item.op == OP_VERTEX;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            plast_reg <= in_item.last;
            for (int a = 0; a < AXES; a++) begin
                poff_reg[a] <= moff_reg[a];
                for (int k = 0; k < AXES; k++) begin
                    prod_reg[a][k] <= prod[a][k];
                end
            end
        end
    end

    always_comb begin
        push.valid      = p_valid_reg;
        push.entry.last = plast_reg;
        for (int a = 0; a < AXES; a++) begin
            sum[a] = SUM_W'(prod_reg[a][0]) + SUM_W'(prod_reg[a][1]) + SUM_W'(prod_reg[a][2])
                   + (SUM_W'(poff_reg[a]) <<< FRAC_SH);
            push.entry.t[a] = clamp_out(sum[a][SUM_W-1:FRAC_SH]);
        end
    end

endmodule

@@ src/tva_fifo.sv @@
// ----------------------------------------------------------------------------
// tva_fifo
// Short queue of transformed vertices between the front and back parts.
// ----------------------------------------------------------------------------
module tva_fifo import tva_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  fifo_push_t   push,
    input  logic         pop,
    output fifo_entry_t  head,
    output fifo_status_t status
);

    fifo_entry_t      mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head          = mem[rd_ptr_reg];
    assign status.count  = count_reg;
    assign status.empty  = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push.valid) - CNT_W'(pop);
        end
    end

endmodule

@@ src/tva_back.sv @@
// ----------------------------------------------------------------------------
// tva_back
// Drains the queue, keeps the running box and holds the result register.
// ----------------------------------------------------------------------------
module tva_back import tva_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fifo_entry_t          head,
    input  fifo_status_t         fifo_status,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output coord_t [AXES-1:0]    out_min,
    output coord_t [AXES-1:0]    out_max
);

    coord_t            low_reg  [AXES];
    coord_t            high_reg [AXES];
    coord_t            low_next [AXES];
    coord_t            high_next[AXES];
    logic              have_reg;
    logic              m_valid_reg;
    coord_t [AXES-1:0] m_min_reg;
    coord_t [AXES-1:0] m_max_reg;
    logic              out_free;

    assign out_free  = !m_valid_reg || out_ready;
    assign pop       = !fifo_status.empty && (!head.last || out_free);
    assign out_valid = m_valid_reg;
    assign out_min   = m_min_reg;
    assign out_max   = m_max_reg;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            low_next[a]  = head.t[a];
            high_next[a] = head.t[a];
            if (have_reg) begin
                low_next[a]  = ($signed(head.t[a]) < $signed(low_reg[a]))  ? head.t[a] : low_reg[a];
                high_next[a] = ($signed(head.t[a]) > $signed(high_reg[a])) ? head.t[a] : high_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                low_reg[a]  <= '0;
                high_reg[a] <= '0;
            end
        end else if (pop) begin
            have_reg <= !head.last;
            for (int a = 0; a < AXES; a++) begin
                low_reg[a]  <= head.last ? '0 : low_next[a];
                high_reg[a] <= head.last ? '0 : high_next[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= pop && head.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head.last) begin
            for (int a = 0; a < AXES; a++) begin
                m_min_reg[a] <= low_next[a];
                m_max_reg[a] <= high_next[a];
            end
        end
    end

endmodule

@@ src/tva_checker.sv @@
// ----------------------------------------------------------------------------
// tva_checker
// Port-level checks on the bounding box block.
// ----------------------------------------------------------------------------
module tva_checker import tva_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input not ready right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[20:0])   <= $signed(m_tdata[83:63]))
                  && ($signed(m_tdata[41:21])  <= $signed(m_tdata[104:84]))
                  && ($signed(m_tdata[62:42])  <= $signed(m_tdata[125:105])))
        else $error("box minimum above maximum");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[127:126] == 2'b00)
        else $error("result padding not zero");

endmodule

bind transformed_vertex_aabb tva_checker u_tva_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ dv/transformed_vertex_aabb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transformed_vertex_aabb_checker
// Watches both stream channels of the vertex bounding-box block, keeps its own
// copy of the affine matrix and the running box, and compares every box that
// leaves the block, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module transformed_vertex_aabb_checker import tva_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatches,
    output int                   boxes_pending,
    output int                   boxes_checked
);

    typedef struct packed {
        coord_t [AXES-1:0] lo;
        coord_t [AXES-1:0] hi;
    } box_t;

    word_t  row_coef [AXES][AXES];
    word_t  row_offset [AXES];
    coord_t run_lo [AXES];
    coord_t run_hi [AXES];
    logic   mesh_open;
    box_t   expected_boxes [$];
    string  axis_tag [AXES] = '{"x", "y", "z"};

    function automatic coord_t transform_axis(int a, word_t vx, word_t vy, word_t vz);
        longint acc;
        acc = longint'(row_coef[a][0]) * longint'(vx)
            + longint'(row_coef[a][1]) * longint'(vy)
            + longint'(row_coef[a][2]) * longint'(vz)
            + longint'(row_offset[a]) * 4096;
        acc = acc >>> 12;
        if (acc > longint'(OUT_MAX)) acc = longint'(OUT_MAX);
        if (acc < longint'(OUT_MIN)) acc = longint'(OUT_MIN);
        return coord_t'(acc);
    endfunction

    always @(posedge aclk) begin : monitor
        box_t   want;
        coord_t got_lo;
        coord_t got_hi;
        coord_t t;
        word_t  vx;
        word_t  vy;
        word_t  vz;
        logic [1:0] row;
        if (!aresetn) begin
            for (int a = 0; a < AXES; a++) begin
                for (int k = 0; k < AXES; k++) row_coef[a][k] = '0;
                row_offset[a] = '0;
                run_lo[a] = '0;
                run_hi[a] = '0;
            end
            mesh_open = 1'b0;
            expected_boxes.delete();
            mismatches = 0;
            boxes_checked = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_boxes.size() == 0) begin
                    $error("box transfer arrived with no box expected");
                    mismatches++;
                end else begin
                    want = expected_boxes.pop_front();
                    for (int a = 0; a < AXES; a++) begin
                        got_lo = m_tdata[a*OUT_W +: OUT_W];
                        got_hi = m_tdata[(a+AXES)*OUT_W +: OUT_W];
                        if (got_lo !== want.lo[a]) begin
                            $error("min_%s: expected %0d, got %0d",
                                   axis_tag[a], want.lo[a], got_lo);
                            mismatches++;
                        end
                        if (got_hi !== want.hi[a]) begin
                            $error("max_%s: expected %0d, got %0d",
                                   axis_tag[a], want.hi[a], got_hi);
                            mismatches++;
                        end
                    end
                end
                boxes_checked++;
            end
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser) == OP_LOAD) begin
                    row = s_tdata[1:0];
                    if (row != ROW_UNUSED) begin
                        for (int k = 0; k < AXES; k++)
                            row_coef[row][k] = s_tdata[2 + k*FIELD_W +: FIELD_W];
                        row_offset[row] = s_tdata[2 + 3*FIELD_W +: FIELD_W];
                    end
                end else begin
                    vx = s_tdata[2 + 4*FIELD_W +: FIELD_W];
                    vy = s_tdata[2 + 5*FIELD_W +: FIELD_W];
                    vz = s_tdata[2 + 6*FIELD_W +: FIELD_W];
                    for (int a = 0; a < AXES; a++) begin
                        t = transform_axis(a, vx, vy, vz);
                        if (!mesh_open || t < run_lo[a]) run_lo[a] = t;
                        if (!mesh_open || t > run_hi[a]) run_hi[a] = t;
                    end
                    mesh_open = 1'b1;
                    if (s_tlast) begin
                        for (int a = 0; a < AXES; a++) begin
                            want.lo[a] = run_lo[a];
                            want.hi[a] = run_hi[a];
                            run_lo[a] = '0;
                            run_hi[a] = '0;
                        end
                        expected_boxes.push_back(want);
                        mesh_open = 1'b0;
                    end
                end
            end
        end
        boxes_pending = expected_boxes.size();
    end

endmodule

@@ dv/transformed_vertex_aabb_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transformed_vertex_aabb_test
// Drives matrix row loads and vertex meshes into the bounding-box block with
// random gaps on both channels, a long output stall and pauses until drained;
// the checker beside the block predicts each box and counts mismatches.
// ----------------------------------------------------------------------------
module transformed_vertex_aabb_test;
    import tva_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int boxes_pending;
    int boxes_checked;
    int n_loads;
    int n_ignored;
    int n_vertices;
    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold;

    transformed_vertex_aabb dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    transformed_vertex_aabb_checker box_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .boxes_pending (boxes_pending),
        .boxes_checked (boxes_checked)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // caller sits at a falling edge; returns at the falling edge after the transfer
    task automatic send_transfer(op_t op, logic [S_TDATA_W-1:0] data, logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = data;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic load_row(logic [1:0] row, logic [15:0] cx, logic [15:0] cy,
                            logic [15:0] cz, logic [15:0] off);
        send_transfer(OP_LOAD, {6'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                                off, cz, cy, cx, row}, 1'($urandom));
        if (row == ROW_UNUSED) n_ignored++;
        else n_loads++;
    endtask

    task automatic put_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                              logic last);
        send_transfer(OP_VERTEX, {6'b0, vz, vy, vx, 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 2'($urandom)}, last);
        n_vertices++;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (boxes_pending != 0) @(negedge aclk);
    endtask

    // result side
    initial begin : receiver
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold) begin
                m_tready = 1'b0;
                repeat (80) @(negedge aclk);
                rx_hold = 1'b0;
            end
            stall = rx_idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int len;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        rx_hold    = 1'b0;
        n_loads    = 0;
        n_ignored  = 0;
        n_vertices = 0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // matrix still at reset: everything maps to zero
        put_vertex(16'h7fff, 16'h8000, 16'h0001, 1'b0);
        put_vertex(16'h8000, 16'h7fff, 16'hffff, 1'b1);
        put_vertex(16'h1234, 16'hedcb, 16'h0000, 1'b1);
        load_row(ROW_UNUSED, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        // near identity with translation
        load_row(2'd0, 16'd4096, 16'h0000, 16'h0000, 16'h0000);
        load_row(2'd1, 16'h0000, 16'd4096, 16'h0000, 16'h0100);
        load_row(2'd2, 16'h0000, 16'h0000, 16'd4096, 16'hff00);
        put_vertex(16'h0100, 16'h0200, 16'h0300, 1'b0);
        put_vertex(16'hff00, 16'hfe00, 16'h0050, 1'b0);
        put_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
        put_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
        // full-scale coefficients
        load_row(2'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        load_row(2'd1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        load_row(2'd2, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        put_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
        put_vertex(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        put_vertex(16'h8000, 16'h7fff, 16'h8000, 1'b1);
        // row reload in the middle of a mesh keeps the running box
        put_vertex(16'hffff, 16'h0001, 16'hffff, 1'b0);
        load_row(2'd2, 16'h0001, 16'hffff, 16'h0000, 16'h0000);
        put_vertex(16'h0001, 16'hffff, 16'h0001, 1'b1);
        load_row(ROW_UNUSED, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        put_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
        wait_drained();

        // output stalled for a long stretch while single-vertex meshes pile up
        rx_hold    = 1'b1;
        tx_idle_on = 1'b0;
        for (int i = 0; i < 14; i++) put_vertex(pick_word(), pick_word(), pick_word(), 1'b1);
        tx_idle_on = 1'b1;
        wait_drained();

        while (n_loads + n_vertices < 1200) begin
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) == 0) begin
                load_row(2'($urandom), pick_word(), pick_word(), pick_word(), pick_word());
            end else begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 19) == 0)
                        load_row(2'($urandom), pick_word(), pick_word(), pick_word(),
                                 pick_word());
                    put_vertex(pick_word(), pick_word(), pick_word(), i == len - 1);
                end
            end
            if ($urandom_range(0, 39) == 0) wait_drained();
        end

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_drained();
        repeat (20) @(negedge aclk);

        $display("Covered %0d row loads, %0d ignored loads and %0d vertices",
                 n_loads, n_ignored, n_vertices);
        $display("%0d boxes checked, including a long output stall with input backpressure",
                 boxes_checked);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
